// ===== sv/ter_pkg.sv =====
// Shared types, register codes and defaults of the triangle edge rasterizer.
package ter_pkg;

  localparam int DEF_MAX_SCREEN_DIM = 4096;
  localparam int DEF_FRACTION_BITS  = 16;

  localparam int RST_SCREEN_WIDTH  = 640;
  localparam int RST_SCREEN_HEIGHT = 480;
  localparam int RST_X_CLIP_STEP   = 205;
  localparam int RST_Y_CLIP_STEP   = 273;

  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_X_CLIP_STEP   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_Y_CLIP_STEP   = 2'd3;

  localparam logic [1:0] VIDX_0    = 2'd0;
  localparam logic [1:0] VIDX_1    = 2'd1;
  localparam logic [1:0] VIDX_2    = 2'd2;
  localparam logic [1:0] VIDX_NONE = 2'd3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX_MINMAX,
    ST_BOX_MUL,
    ST_BOX_CLAMP,
    ST_CORNER,
    ST_EDGE,
    ST_EMIT
  } back_state_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [1:0] idx;
  } q_head_t;

endpackage

// ===== sv/triangle_edge_rasterizer_top.sv =====
// Top level of the bounding-box edge-function triangle rasterizer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: operation; tdata: vertex_index,
//          |     |                     |   vertex_x, vertex_y
//  out_    | out | out_tvalid/tready   | tdata: pixel_x, pixel_y; tuser:
//          |     |                     |   inside_res; tlast: last
//  cfg_    | in  | cfg_wen             | cfg_addr register index, cfg_wdata
//
// A vertex load runs through the back-end steps pick up, min/max, bound
// multiply and clamp. A pixel step runs pick up, corner multiply, each edge
// product in turn on one pair of multipliers, and the result write. A
// step on a finished or empty box is answered in the pick-up state. The edge
// unit sets the pixel rate. Reset is synchronous and active low; it restores
// the default screen and an empty scan. While the result register waits on
// out_tready, the two-entry queue accepts until full and the result write holds.
module triangle_edge_rasterizer_top import ter_pkg::*; #(
  parameter int MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS,
  parameter int VW   = FRACTION_BITS + 2,
  parameter int DW   = $clog2(MAX_SCREEN_DIM) + 1,
  parameter int PW   = DW - 1,
  parameter int CFGW = (DW > VW) ? DW : VW,
  parameter int IDW  = ((2 + 2 * VW + 7) / 8) * 8,
  parameter int ODW  = ((2 * PW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFGW-1:0]   cfg_wdata,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IDW-1:0]    in_tdata,   // vertex_index, vertex_x, vertex_y, zero pad
  input  logic              in_tuser,   // operation
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ODW-1:0]    out_tdata,  // pixel_x, pixel_y, zero pad
  output logic              out_tuser,  // inside_res
  output logic              out_tlast   // last
);

  q_head_t              head;
  logic signed [VW-1:0] head_x, head_y;
  logic                 pop;
  op_t                  in_op;
  logic [PW-1:0]        px, py;

  // unpack the request
  assign in_op = op_t'(in_tuser);

  ter_front #(.VW(VW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_op),
    .in_idx    (in_tdata[1:0]),
    .in_x      (in_tdata[2 +: VW]),
    .in_y      (in_tdata[2 + VW +: VW]),
    .head      (head),
    .head_x    (head_x),
    .head_y    (head_y),
    .pop       (pop)
  );

  ter_back #(
    .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
    .FRACTION_BITS  (FRACTION_BITS),
    .VW             (VW),
    .DW             (DW),
    .PW             (PW),
    .CFGW           (CFGW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_x     (head_x),
    .head_y     (head_y),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_px     (px),
    .out_py     (py),
    .out_inside (out_tuser),
    .out_last   (out_tlast)
  );

  // pack the result, pixel_x lowest
  assign out_tdata = ODW'({py, px});

endmodule

// ===== sv/ter_front.sv =====
// Front end: accept requests, drop void vertex loads, two-entry queue.
module ter_front import ter_pkg::*; #(
  parameter int VW = DEF_FRACTION_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  op_t                  in_op,
  input  logic [1:0]           in_idx,
  input  logic signed [VW-1:0] in_x,
  input  logic signed [VW-1:0] in_y,
  output q_head_t              head,
  output logic signed [VW-1:0] head_x,
  output logic signed [VW-1:0] head_y,
  input  logic                 pop
);

  op_t                  op_r  [2];
  logic [1:0]           idx_r [2];
  logic signed [VW-1:0] x_r   [2];
  logic signed [VW-1:0] y_r   [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push;
  logic                 do_pop;

  assign in_tready = (cnt_r != 2'd2);
  // Keep steps and loads of a real vertex; drop the rest on accept.
  assign push   = in_tvalid && in_tready && ((in_op == OP_STEP) || (in_idx != VIDX_NONE));
  assign do_pop = pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_r[wr_ptr_r]  <= in_op;
      idx_r[wr_ptr_r] <= in_idx;
      x_r[wr_ptr_r]   <= in_x;
      y_r[wr_ptr_r]   <= in_y;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.op    = op_r[rd_ptr_r];
  assign head.idx   = idx_r[rd_ptr_r];
  assign head_x     = x_r[rd_ptr_r];
  assign head_y     = y_r[rd_ptr_r];

endmodule

// ===== sv/ter_back.sv =====
// Back end: box setup, scan counters, edge test and result register.
module ter_back import ter_pkg::*; #(
  parameter int MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS,
  parameter int VW   = FRACTION_BITS + 2,
  parameter int DW   = $clog2(MAX_SCREEN_DIM) + 1,
  parameter int PW   = DW - 1,
  parameter int CFGW = (DW > VW) ? DW : VW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFGW-1:0]      cfg_wdata,
  input  q_head_t              head,
  input  logic signed [VW-1:0] head_x,
  input  logic signed [VW-1:0] head_y,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PW-1:0]        out_px,
  output logic [PW-1:0]        out_py,
  output logic                 out_inside,
  output logic                 out_last
);

  localparam int SW  = VW;
  localparam int CW  = DW + SW + 1;
  localparam int NW  = VW + DW + 3;
  localparam int MW  = CW + VW + 2;
  localparam longint ONE = longint'(1) << FRACTION_BITS;

  back_state_t state_r, state_nxt;

  logic [DW-1:0] width_r, height_r;
  logic [SW-1:0] xstep_r, ystep_r;

  logic signed [VW-1:0] vx_r [3];
  logic signed [VW-1:0] vy_r [3];
  logic signed [VW-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic signed [NW-1:0] num_r [4];
  logic [DW-1:0] bx0_r, bx1_r, by0_r, by1_r;
  logic [DW-1:0] col_r, row_r;
  logic          fin_r;
  logic signed [CW-1:0] xc_r, yc_r;
  logic [1:0]           edge_r;
  logic signed [MW-1:0] p1_r, p2_r;
  logic                 inside_r;

  logic          out_valid_r;
  logic [PW-1:0] out_px_r, out_py_r;
  logic          out_inside_r, out_last_r;

  logic out_free;
  logic emit_done, emit_pix;

  assign out_free = !out_valid_r || out_tready;

  // ---------------- box min/max ----------------
  logic signed [VW-1:0] minx, maxx, miny, maxy;
  always_comb begin
    minx = VW'(ONE);
    miny = VW'(ONE);
    maxx = -VW'(ONE);
    maxy = -VW'(ONE);
    for (int i = 0; i < 3; i++) begin
      if (vx_r[i] < minx) minx = vx_r[i];
      if (vx_r[i] > maxx) maxx = vx_r[i];
      if (vy_r[i] < miny) miny = vy_r[i];
      if (vy_r[i] > maxy) maxy = vy_r[i];
    end
  end

  // (p + 1) * dim, p one bit wider so that the negated y bound fits
  logic signed [VW:0]   pb [4];
  logic signed [NW-1:0] num_nxt [4];
  always_comb begin
    pb[0] = (VW+1)'(minx_r);
    pb[1] = (VW+1)'(maxx_r);
    pb[2] = -(VW+1)'(maxy_r);
    pb[3] = -(VW+1)'(miny_r);
    for (int i = 0; i < 4; i++) begin
      num_nxt[i] = NW'((VW+2)'(pb[i]) + (VW+2)'(ONE)) *
                   $signed(NW'({1'b0, (i < 2) ? width_r : height_r}));
    end
  end

  function automatic logic [DW-1:0] to_pixel(input logic signed [NW-1:0] num,
                                             input logic [DW-1:0] dim);
    logic signed [NW-1:0] r;
    r = num >>> (FRACTION_BITS + 1);
    if (num < 0)                          to_pixel = '0;
    else if (r > $signed(NW'({1'b0, dim}))) to_pixel = dim;
    else                                  to_pixel = r[DW-1:0];
  endfunction

  logic [DW-1:0] bx0_c, bx1_c, by0_c, by1_c;
  always_comb begin
    bx0_c = to_pixel(num_r[0], width_r);
    bx1_c = to_pixel(num_r[1], width_r);
    by0_c = to_pixel(num_r[2], height_r);
    by1_c = to_pixel(num_r[3], height_r);
  end

  // ---------------- pixel corner ----------------
  logic [DW+SW-1:0]     prod_x, prod_y;
  logic signed [CW-1:0] xc_nxt, yc_nxt;
  always_comb begin
    prod_x = (DW+SW)'(col_r) * (DW+SW)'(xstep_r);
    prod_y = (DW+SW)'(row_r) * (DW+SW)'(ystep_r);
    xc_nxt = $signed({1'b0, prod_x}) - CW'(ONE);
    yc_nxt = CW'(ONE) - $signed({1'b0, prod_y});
  end

  // ---------------- edge products ----------------
  logic signed [VW-1:0] ax, ay, bx, by;
  always_comb begin
    unique case (edge_r)
      2'd0:    begin ax = vx_r[0]; ay = vy_r[0]; bx = vx_r[1]; by = vy_r[1]; end
      2'd1:    begin ax = vx_r[1]; ay = vy_r[1]; bx = vx_r[2]; by = vy_r[2]; end
      default: begin ax = vx_r[2]; ay = vy_r[2]; bx = vx_r[0]; by = vy_r[0]; end
    endcase
  end

  logic signed [CW:0]   dx, dy;
  logic signed [VW:0]   ex, ey;
  logic signed [MW-1:0] p1_nxt, p2_nxt;
  logic signed [MW:0]   ediff;
  logic                 neg;
  always_comb begin
    dx     = (CW+1)'(xc_r) - (CW+1)'(ax);
    dy     = (CW+1)'(yc_r) - (CW+1)'(ay);
    ey     = (VW+1)'(ay) - (VW+1)'(by);
    ex     = (VW+1)'(ax) - (VW+1)'(bx);
    p1_nxt = MW'(dx) * MW'(ey);
    p2_nxt = MW'(dy) * MW'(ex);
    ediff  = (MW+1)'(p1_r) - (MW+1)'(p2_r);
    neg    = ediff[MW];
  end

  logic [DW:0] col_inc, row_inc;
  logic        col_wrap, row_end, pix_last;
  always_comb begin
    col_inc  = {1'b0, col_r} + 1'b1;
    row_inc  = {1'b0, row_r} + 1'b1;
    col_wrap = col_inc >= {1'b0, bx1_r};
    row_end  = row_inc >= {1'b0, by1_r};
    pix_last = col_wrap && row_end;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.op == OP_LOAD) state_nxt = ST_BOX_MINMAX;
          else if (!fin_r)        state_nxt = ST_CORNER;
        end
      end
      ST_BOX_MINMAX: state_nxt = ST_BOX_MUL;
      ST_BOX_MUL:    state_nxt = ST_BOX_CLAMP;
      ST_BOX_CLAMP:  state_nxt = ST_IDLE;
      ST_CORNER:     state_nxt = ST_EDGE;
      ST_EDGE:       if (edge_r == 2'd2) state_nxt = ST_EMIT;
      ST_EMIT:       if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    pop       = 1'b0;
    emit_done = 1'b0;
    emit_pix  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.op == OP_LOAD) pop = 1'b1;
          else if (!fin_r)        pop = 1'b1;
          else if (out_free) begin
            pop       = 1'b1;
            emit_done = 1'b1;
          end
        end
      end
      ST_EMIT: emit_pix = out_free;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      width_r  <= DW'(RST_SCREEN_WIDTH);
      height_r <= DW'(RST_SCREEN_HEIGHT);
      xstep_r  <= SW'(RST_X_CLIP_STEP);
      ystep_r  <= SW'(RST_Y_CLIP_STEP);
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
      bx0_r <= '0;
      bx1_r <= '0;
      by0_r <= '0;
      by1_r <= '0;
      col_r <= '0;
      row_r <= '0;
      fin_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[DW-1:0];
          REG_SCREEN_HEIGHT: height_r <= cfg_wdata[DW-1:0];
          REG_X_CLIP_STEP:   xstep_r  <= cfg_wdata[SW-1:0];
          REG_Y_CLIP_STEP:   ystep_r  <= cfg_wdata[SW-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && head.valid && head.op == OP_LOAD) begin
        unique case (head.idx)
          VIDX_0:  begin vx_r[0] <= head_x; vy_r[0] <= head_y; end
          VIDX_1:  begin vx_r[1] <= head_x; vy_r[1] <= head_y; end
          VIDX_2:  begin vx_r[2] <= head_x; vy_r[2] <= head_y; end
          default: ;
        endcase
      end
      if (state_r == ST_BOX_CLAMP) begin
        bx0_r <= bx0_c;
        bx1_r <= bx1_c;
        by0_r <= by0_c;
        by1_r <= by1_c;
        col_r <= bx0_c;
        row_r <= by0_c;
        fin_r <= (bx1_c <= bx0_c) || (by1_c <= by0_c);
      end
      if (emit_pix) begin
        // advance the scan in row-major order
        if (col_wrap) begin
          col_r <= bx0_r;
          row_r <= row_inc[DW-1:0];
          if (row_end) fin_r <= 1'b1;
        end else begin
          col_r <= col_inc[DW-1:0];
        end
      end
      if (emit_done || emit_pix) out_valid_r <= 1'b1;
      else if (out_tready)       out_valid_r <= 1'b0;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_BOX_MINMAX) begin
      minx_r <= minx;
      maxx_r <= maxx;
      miny_r <= miny;
      maxy_r <= maxy;
    end
    if (state_r == ST_BOX_MUL) begin
      for (int i = 0; i < 4; i++) num_r[i] <= num_nxt[i];
    end
    if (state_r == ST_CORNER) begin
      xc_r     <= xc_nxt;
      yc_r     <= yc_nxt;
      edge_r   <= 2'd0;
      inside_r <= 1'b1;
    end
    if (state_r == ST_EDGE) begin
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      edge_r <= edge_r + 2'd1;
      if (edge_r != 2'd0) inside_r <= inside_r & neg;
    end
    if (emit_done) begin
      out_px_r     <= '0;
      out_py_r     <= '0;
      out_inside_r <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (emit_pix) begin
      out_px_r     <= col_r[PW-1:0];
      out_py_r     <= row_r[PW-1:0];
      out_inside_r <= inside_r & neg;
      out_last_r   <= pix_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_px     = out_px_r;
  assign out_py     = out_py_r;
  assign out_inside = out_inside_r;
  assign out_last   = out_last_r;

endmodule

// ===== tb/triangle_edge_rasterizer_top_tb.sv =====
// Testbench for the triangle edge rasterizer: vertex loads and pixel steps checked against a predictor.
`timescale 1ns / 1ps

module triangle_edge_rasterizer_top_tb;
  import ter_pkg::*;

  localparam int VW   = 18;
  localparam int IDW  = 40;
  localparam int ODW  = 24;
  localparam int CFGW = 18;
  localparam longint ONE_Q = 64'sd65536;

  typedef struct packed {
    op_t        op;
    logic [1:0] vidx;
    logic [17:0] vx;
    logic [17:0] vy;
  } request_t;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        hit;
    logic        last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFGW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IDW-1:0] in_tdata = '0;   // vertex_index, vertex_x, vertex_y, zero pad
  logic in_tuser = 1'b0;           // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ODW-1:0] out_tdata;       // pixel_x, pixel_y, zero pad
  logic out_tuser;                 // inside_res
  logic out_tlast;                 // last

  triangle_edge_rasterizer_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: configuration, vertices, box and scan position.
  longint scr_w, scr_h, step_x, step_y;
  longint vert_x [3];
  longint vert_y [3];
  longint col_lo, col_end, row_lo, row_end, cur_col, cur_row;
  bit     scan_done;

  request_t request_q[$];
  pixel_t   pixel_q[$];
  int mismatches = 0;
  int hold_off = 0;
  bit long_hold_done = 0;

  function automatic longint to_pixel(longint p, longint dim);
    longint num;
    num = (p + ONE_Q) * dim;
    if (num < 0) return 0;
    num = num >>> 17;
    return (num > dim) ? dim : num;
  endfunction

  function automatic longint edge_val(longint x, longint y, int a, int b);
    return (x - vert_x[a]) * (vert_y[a] - vert_y[b]) - (y - vert_y[a]) * (vert_x[a] - vert_x[b]);
  endfunction

  task automatic predict_reset();
    scr_w = RST_SCREEN_WIDTH; scr_h = RST_SCREEN_HEIGHT;
    step_x = RST_X_CLIP_STEP; step_y = RST_Y_CLIP_STEP;
    for (int i = 0; i < 3; i++) begin vert_x[i] = 0; vert_y[i] = 0; end
    col_lo = 0; col_end = 0; row_lo = 0; row_end = 0; cur_col = 0; cur_row = 0;
    scan_done = 1;
  endtask

  // Work out the pixel that a request produces, if any.
  task automatic predict_pixel(request_t r);
    longint mnx, mny, mxx, mxy, x, y;
    pixel_t p;
    bit ins;
    mnx = ONE_Q; mny = ONE_Q; mxx = -ONE_Q; mxy = -ONE_Q;
    if (r.op == OP_LOAD) begin
      if (r.vidx == VIDX_NONE) return;
      vert_x[r.vidx] = longint'(signed'(r.vx));
      vert_y[r.vidx] = longint'(signed'(r.vy));
      for (int i = 0; i < 3; i++) begin
        if (vert_x[i] < mnx) mnx = vert_x[i];
        if (vert_x[i] > mxx) mxx = vert_x[i];
        if (vert_y[i] < mny) mny = vert_y[i];
        if (vert_y[i] > mxy) mxy = vert_y[i];
      end
      col_lo = to_pixel(mnx, scr_w); col_end = to_pixel(mxx, scr_w);
      row_lo = to_pixel(-mxy, scr_h); row_end = to_pixel(-mny, scr_h);
      cur_col = col_lo; cur_row = row_lo;
      scan_done = (col_end <= col_lo) || (row_end <= row_lo);
      return;
    end
    if (scan_done) begin
      p = '{px: 0, py: 0, hit: 0, last: 1};
      pixel_q.push_back(p);
      return;
    end
    x = cur_col * step_x - ONE_Q;
    y = ONE_Q - cur_row * step_y;
    ins = edge_val(x, y, 0, 1) < 0 && edge_val(x, y, 1, 2) < 0 && edge_val(x, y, 2, 0) < 0;
    p.px = cur_col[11:0]; p.py = cur_row[11:0]; p.hit = ins;
    p.last = (cur_col + 1 >= col_end) && (cur_row + 1 >= row_end);
    pixel_q.push_back(p);
    cur_col++;
    if (cur_col >= col_end) begin
      cur_col = col_lo; cur_row++;
      if (cur_row >= row_end) scan_done = 1;
    end
  endtask

  // Driver: offer queued requests with random gaps; predict on acceptance.
  int gap = 0;
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      predict_pixel(request_q.pop_front());
    end
    if (in_tvalid && !in_tready) begin
      // hold the current request
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_tvalid <= 1'b0;
    end else if ((in_tvalid && in_tready ? request_q.size() : request_q.size()) > 0
                 && rst_n) begin
      in_tvalid <= 1'b1;
      in_tuser  <= request_q[0].op;
      in_tdata  <= {2'b00, request_q[0].vy, request_q[0].vx, request_q[0].vidx};
      if ($urandom_range(0, 9) < 2) gap <= ($urandom_range(0, 19) == 0)
                                           ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Monitor: compare every accepted pixel with the oldest prediction.
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{px: out_tdata[11:0], py: out_tdata[23:12], hit: out_tuser, last: out_tlast};
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %p", got);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("pixel mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Receiver stalls, including one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && pixel_q.size() >= 2) begin
      long_hold_done <= 1;
      hold_off <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 49) == 0) hold_off <= $urandom_range(5, 30);
    end
  end

  function automatic request_t make_load(logic [1:0] idx, logic [17:0] x, logic [17:0] y);
    request_t r;
    r.op = OP_LOAD; r.vidx = idx; r.vx = x; r.vy = y;
    return r;
  endfunction

  function automatic request_t make_step();
    request_t r;
    r.op = OP_STEP; r.vidx = 2'($urandom); r.vx = 18'($urandom); r.vy = 18'($urandom);
    return r;
  endfunction

  // Clip coordinate within 2048 of c so boxes stay small (at most 1/32 of the screen per axis).
  function automatic logic [17:0] near(int c);
    return 18'(c + $signed($urandom_range(0, 4095)) - 2048);
  endfunction

  task automatic wait_drained();
    while (request_q.size() > 0 || in_tvalid || pixel_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFGW-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w  = val & 18'h1FFF;
      REG_SCREEN_HEIGHT: scr_h  = val & 18'h1FFF;
      REG_X_CLIP_STEP:   step_x = val;
      default:           step_y = val;
    endcase
  endtask

  // Queue one triangle near (cx, cy), then nsteps pixel steps.
  task automatic queue_triangle(int cx, int cy, int nsteps);
    int order;
    order = $urandom_range(0, 1);
    request_q.push_back(make_load(VIDX_0, near(cx), near(cy)));
    request_q.push_back(make_load(order ? VIDX_2 : VIDX_1, near(cx), near(cy)));
    request_q.push_back(make_load(order ? VIDX_1 : VIDX_2, near(cx), near(cy)));
    for (int i = 0; i < nsteps; i++) request_q.push_back(make_step());
  endtask

  initial begin
    int phase;
    predict_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: step on empty box, ignored load, extreme vertices, tiny triangle.
    request_q.push_back(make_step());
    request_q.push_back(make_load(VIDX_NONE, 18'h1FFFF, 18'h20000));
    request_q.push_back(make_step());
    request_q.push_back(make_load(VIDX_0, 18'h20000, 18'h1FFFF));
    request_q.push_back(make_load(VIDX_1, 18'h1FFFF, 18'h20000));
    request_q.push_back(make_load(VIDX_2, 18'h3FFFF, 18'h00000));
    for (int i = 0; i < 6; i++) request_q.push_back(make_step());
    request_q.push_back(make_load(VIDX_0, 18'h3F000, 18'h00800));
    request_q.push_back(make_load(VIDX_1, 18'h00800, 18'h00800));
    request_q.push_back(make_load(VIDX_2, 18'h00000, 18'h3F000));
    for (int i = 0; i < 8; i++) request_q.push_back(make_step());
    wait_drained();

    // Phases with varied screens: small, extremes, and oversized (masked coordinates).
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_SCREEN_WIDTH, 1); write_reg(REG_SCREEN_HEIGHT, 1);
                 write_reg(REG_X_CLIP_STEP, 131072); write_reg(REG_Y_CLIP_STEP, 131072); end
        1: begin write_reg(REG_SCREEN_WIDTH, 4096); write_reg(REG_SCREEN_HEIGHT, 4096);
                 write_reg(REG_X_CLIP_STEP, 32); write_reg(REG_Y_CLIP_STEP, 1); end
        2: begin write_reg(REG_SCREEN_WIDTH, 8191); write_reg(REG_SCREEN_HEIGHT, 0);
                 write_reg(REG_X_CLIP_STEP, 16); write_reg(REG_Y_CLIP_STEP, 16); end
        3: begin write_reg(REG_SCREEN_WIDTH, 8191); write_reg(REG_SCREEN_HEIGHT, 8191);
                 write_reg(REG_X_CLIP_STEP, 16); write_reg(REG_Y_CLIP_STEP, 262143); end
        default: begin
          write_reg(REG_SCREEN_WIDTH, $urandom_range(16, 256));
          write_reg(REG_SCREEN_HEIGHT, $urandom_range(16, 256));
          write_reg(REG_X_CLIP_STEP, $urandom_range(1, 131072));
          write_reg(REG_Y_CLIP_STEP, $urandom_range(1, 131072));
        end
      endcase
      for (int t = 0; t < 12; t++) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: random loads including the ignored index, stray steps
          request_q.push_back(make_load(2'($urandom), 18'($urandom), 18'($urandom)));
          request_q.push_back(make_step());
        end else begin
          queue_triangle($signed($urandom_range(0, 120000)) - 60000,
                         $signed($urandom_range(0, 120000)) - 60000,
                         (phase == 0) ? 3 : $urandom_range(4, 20));
        end
      end
      // a reconfiguration mid-triangle: box keeps old sizes, steps use new step
      if (phase == 5) begin
        request_q.push_back(make_load(VIDX_0, near(0), near(0)));
        wait_drained();
        write_reg(REG_X_CLIP_STEP, $urandom_range(1, 131072));
        for (int i = 0; i < 10; i++) request_q.push_back(make_step());
      end
      wait_drained();
    end

    // Random bulk on the default-like screen.
    write_reg(REG_SCREEN_WIDTH, 640); write_reg(REG_SCREEN_HEIGHT, 480);
    write_reg(REG_X_CLIP_STEP, 205); write_reg(REG_Y_CLIP_STEP, 273);
    for (int t = 0; t < 35; t++)
      queue_triangle($signed($urandom_range(0, 120000)) - 60000,
                     $signed($urandom_range(0, 120000)) - 60000, $urandom_range(5, 25));
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
